>>> rtl/xcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcr_pkg
// shared types and constants of the character reference decoder
// ----------------------------------------------------------------------------
package xcr_pkg;

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_AMP,
        PH_NAME,
        PH_NUM,
        PH_BADNUM,
        PH_DISCARD
    } t_phase;

    localparam int CODE_W = 21;
    localparam logic [CODE_W-1:0] CODE_LIMIT = 21'h1FFFFF;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_EMPTY        = 3'd2;
    localparam logic [2:0] ERR_BAD_DIGIT    = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN      = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE    = 3'd5;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
    localparam logic [31:0] NAME_GT   = 32'h0000_6774;
    localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
    localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;
    localparam logic [31:0] NAME_APOS = 32'h6170_6F73;

    localparam logic [CODE_W-1:0] UTF_2B = 21'h80;
    localparam logic [CODE_W-1:0] UTF_3B = 21'h800;
    localparam logic [CODE_W-1:0] UTF_4B = 21'h10000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one queued command: a raw byte, a code to encode, or an error
    typedef struct packed {
        logic              raw;
        logic [CODE_W-1:0] code;
        logic [2:0]        err;
        logic              eot;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/xcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcr_queue
// small command fifo between the parser and the utf-8 encoder
// ----------------------------------------------------------------------------
module xcr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xcr_pkg::t_cmd i_push_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output xcr_pkg::t_cmd      o_cmd
);
    import xcr_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_do_pop;

    assign w_do_pop = i_pop && (r_count != '0);
    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/xcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcr_front
// reference parser: tracks the phase, gathers names and digits, queues commands
// ----------------------------------------------------------------------------
module xcr_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eot,
    output logic            o_ready,
    input  wire logic       i_q_full,
    output logic            o_push,
    output xcr_pkg::t_cmd   o_cmd
);
    import xcr_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [31:0]       r_name;
    logic [31:0]       n_name;
    logic [2:0]        r_name_len;
    logic [2:0]        n_name_len;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] n_code;
    logic              r_ovf;
    logic              n_ovf;
    logic              r_hex;
    logic              n_hex;
    logic              r_have;
    logic              n_have;

    logic              w_accept;
    logic              w_semi;
    logic              w_is_x;
    logic              w_dig_ok;
    logic [3:0]        w_dig;
    logic [25:0]       w_acc;
    logic              w_has_cmd;
    logic              w_clear;
    logic [CODE_W-1:0] w_named;
    logic              w_named_ok;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_has_cmd;
    assign w_semi   = (i_byte == CH_SEMI);
    assign w_is_x   = (i_byte == CH_LX) || (i_byte == CH_UX);

    // digit decode
    always_comb begin
        w_dig    = '0;
        w_dig_ok = 1'b0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_dig    = i_byte[3:0];
            w_dig_ok = 1'b1;
        end else if (r_hex && ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                               (i_byte >= 8'h41 && i_byte <= 8'h46))) begin
            w_dig    = i_byte[3:0] + 4'd9;
            w_dig_ok = 1'b1;
        end
    end

    always_comb begin
        if (r_hex) begin
            w_acc = {1'b0, r_code, 4'b0} + 26'(w_dig);
        end else begin
            w_acc = {2'b0, r_code, 3'b0} + {4'b0, r_code, 1'b0} + 26'(w_dig);
        end
    end

    // named entity lookup
    always_comb begin
        w_named_ok = 1'b1;
        w_named    = '0;
        if (r_name_len == 3'd2 && r_name == NAME_LT) begin
            w_named = CODE_W'(CH_LT);
        end else if (r_name_len == 3'd2 && r_name == NAME_GT) begin
            w_named = CODE_W'(CH_GT);
        end else if (r_name_len == 3'd3 && r_name == NAME_AMP) begin
            w_named = CODE_W'(CH_AMP);
        end else if (r_name_len == 3'd4 && r_name == NAME_QUOT) begin
            w_named = CODE_W'(CH_QUOT);
        end else if (r_name_len == 3'd4 && r_name == NAME_APOS) begin
            w_named = CODE_W'(CH_APOS);
        end else begin
            w_named_ok = 1'b0;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_DISCARD: begin
                if (i_eot) n_phase = PH_PLAIN;
            end
            PH_PLAIN: begin
                if (i_byte == CH_AMP && !i_eot) n_phase = PH_AMP;
            end
            default: begin
                if (w_semi) begin
                    n_phase = PH_PLAIN;
                    unique case (r_phase)
                        PH_BADNUM: if (!i_eot) n_phase = PH_DISCARD;
                        PH_NUM: begin
                            if (!i_eot && (!r_have || r_ovf)) n_phase = PH_DISCARD;
                        end
                        PH_NAME: if (!i_eot && !w_named_ok) n_phase = PH_DISCARD;
                        default: if (!i_eot) n_phase = PH_DISCARD;
                    endcase
                end else if (i_eot) begin
                    n_phase = PH_PLAIN;
                end else begin
                    unique case (r_phase)
                        PH_AMP: n_phase = (i_byte == CH_HASH) ? PH_NUM : PH_NAME;
                        PH_NUM: begin
                            if (!(!r_have && !r_hex && w_is_x) && !w_dig_ok) begin
                                n_phase = PH_BADNUM;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        endcase
    end

    // command and reference datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.eot  = i_eot;
        w_has_cmd  = 1'b0;
        w_clear    = 1'b0;
        n_name     = r_name;
        n_name_len = r_name_len;
        n_code     = r_code;
        n_ovf      = r_ovf;
        n_hex      = r_hex;
        n_have     = r_have;
        unique case (r_phase)
            PH_DISCARD: begin
                w_has_cmd = 1'b0;
            end
            PH_PLAIN: begin
                if (i_byte == CH_AMP) begin
                    w_clear = 1'b1;
                    if (i_eot) begin
                        w_has_cmd = 1'b1;
                        o_cmd.err = ERR_UNTERMINATED;
                    end
                end else begin
                    w_has_cmd  = 1'b1;
                    o_cmd.raw  = 1'b1;
                    o_cmd.code = CODE_W'(i_byte);
                end
            end
            default: begin
                if (w_semi) begin
                    w_has_cmd = 1'b1;
                    w_clear   = 1'b1;
                    unique case (r_phase)
                        PH_BADNUM: o_cmd.err = ERR_BAD_DIGIT;
                        PH_NUM: begin
                            if (!r_have)     o_cmd.err = ERR_EMPTY;
                            else if (r_ovf)  o_cmd.err = ERR_TOO_LARGE;
                            else             o_cmd.code = r_code;
                        end
                        PH_NAME: begin
                            if (w_named_ok) o_cmd.code = w_named;
                            else            o_cmd.err  = ERR_UNKNOWN;
                        end
                        default: o_cmd.err = ERR_UNKNOWN;
                    endcase
                end else begin
                    // body byte: name bytes or digits
                    if (r_phase == PH_NAME ||
                        (r_phase == PH_AMP && i_byte != CH_HASH)) begin
                        if (r_name_len < 3'd4) n_name = {r_name[23:0], i_byte};
                        if (r_name_len < 3'd5) n_name_len = r_name_len + 1'b1;
                    end else if (r_phase == PH_NUM) begin
                        if (!r_have && !r_hex && w_is_x) begin
                            n_hex = 1'b1;
                        end else if (w_dig_ok) begin
                            n_have = 1'b1;
                            if (!r_ovf) begin
                                if (w_acc > 26'(CODE_LIMIT)) n_ovf = 1'b1;
                                else n_code = w_acc[CODE_W-1:0];
                            end
                        end
                    end
                    if (i_eot) begin
                        w_has_cmd = 1'b1;
                        w_clear   = 1'b1;
                        o_cmd.err = ERR_UNTERMINATED;
                    end
                end
            end
        endcase
        if (w_clear) begin
            n_name     = '0;
            n_name_len = '0;
            n_code     = '0;
            n_ovf      = 1'b0;
            n_hex      = 1'b0;
            n_have     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PLAIN;
            r_name     <= '0;
            r_name_len <= '0;
            r_code     <= '0;
            r_ovf      <= 1'b0;
            r_hex      <= 1'b0;
            r_have     <= 1'b0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_name     <= n_name;
            r_name_len <= n_name_len;
            r_code     <= n_code;
            r_ovf      <= n_ovf;
            r_hex      <= n_hex;
            r_have     <= n_have;
        end
    end

endmodule
`default_nettype wire

>>> rtl/xcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcr_back
// utf-8 encoder: while the receiver is ready, expands one command into output bytes, one per cycle
// ----------------------------------------------------------------------------
module xcr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire xcr_pkg::t_cmd i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last_of_run,
    output logic               o_text_done,
    output logic [2:0]         o_err
);
    import xcr_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last_of_run;
    logic       r_text_done;
    logic [2:0] r_err;

    logic       w_load;
    logic [1:0] w_nlast;
    logic       w_last;
    logic [1:0] w_rem;
    logic [7:0] w_byte;
    logic [CODE_W-1:0] w_c;

    assign w_c    = i_q_cmd.code;
    assign w_load = !r_valid || i_ready;
    assign w_last = (r_idx == w_nlast);
    assign o_pop  = w_load && i_q_valid && w_last;
    assign w_rem  = w_nlast - r_idx;

    // index of the final byte of this command
    always_comb begin
        if (i_q_cmd.raw || i_q_cmd.err != ERR_NONE || w_c < UTF_2B) begin
            w_nlast = 2'd0;
        end else if (w_c < UTF_3B) begin
            w_nlast = 2'd1;
        end else if (w_c < UTF_4B) begin
            w_nlast = 2'd2;
        end else begin
            w_nlast = 2'd3;
        end
    end

    always_comb begin
        if (i_q_cmd.err != ERR_NONE) begin
            w_byte = 8'h00;
        end else if (r_idx == 2'd0) begin
            unique case (w_nlast)
                2'd0:    w_byte = w_c[7:0];
                2'd1:    w_byte = 8'hC0 | {3'b0, w_c[10:6]};
                2'd2:    w_byte = 8'hE0 | {4'b0, w_c[15:12]};
                default: w_byte = 8'hF0 | {5'b0, w_c[20:18]};
            endcase
        end else begin
            // continuation bytes, counted back from the final one
            unique case (w_rem)
                2'd0:    w_byte = {2'b10, w_c[5:0]};
                2'd1:    w_byte = {2'b10, w_c[11:6]};
                default: w_byte = {2'b10, w_c[17:12]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_last ? 2'd0 : r_idx + 1'b1;
            end
        end
    end

    // an error request always closes the text
    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_byte        <= w_byte;
            r_last_of_run <= w_last;
            r_text_done   <= w_last && (i_q_cmd.eot || i_q_cmd.err != ERR_NONE);
            r_err         <= i_q_cmd.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte        = r_byte;
    assign o_last_of_run = r_last_of_run;
    assign o_text_done   = r_text_done;
    assign o_err         = r_err;

endmodule
`default_nettype wire

>>> rtl/xml_char_reference_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_char_reference_decoder
// unescapes xml character references in a byte stream into utf-8
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while s_axis_tready is high. Plain bytes pass
// through the command queue and then the output register; a closing semicolon
// of a numeric reference expands into one to four utf-8 bytes, emitted by the
// encoder stage. Output bytes leave one per cycle while m_axis_tready is high.
// A 4-entry command queue between the parser and the encoder lets input keep
// flowing while a multi-byte code drains; once it fills, s_axis_tready drops
// until the encoder catches up. A faulty reference gives one error request
// (tdata 0) and the rest of that text is dropped up to the byte marked with
// tlast.
// ----------------------------------------------------------------------------
module xml_char_reference_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // text_done
    output logic [3:0]      m_axis_tuser    // [0] last_of_run, [3:1] error_code
);
    import xcr_pkg::*;

    logic w_q_full;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_last_of_run;
    logic [2:0] w_err;

    xcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    xcr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd)
    );

    xcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_byte        (m_axis_tdata),
        .o_last_of_run (w_last_of_run),
        .o_text_done   (m_axis_tlast),
        .o_err         (w_err)
    );

    assign m_axis_tuser = {w_err, w_last_of_run};

endmodule
`default_nettype wire

>>> test/xml_char_reference_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_char_reference_decoder_tb
// streams escaped text through the decoder and checks each utf-8 request
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes (extremes, each error kind, discard after
// an error) is followed by random texts built from well-formed named
// and numeric references, mixed with plain bytes and broken references. A
// behavioral decoder inside the bench predicts the output requests of the
// random texts and of the untyped rows; both stream sides idle at random and
// the receiver now and then holds off long enough to back the decoder up into
// its input.
module xml_char_reference_decoder_tb;
    import xcr_pkg::*;

    localparam int RANDOM_ITEMS = 233;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIR        = 27;

    typedef struct packed {
        logic [7:0] ch;     // out_byte
        logic       last;   // last_of_run
        logic       done;   // text_done
        logic [2:0] err;
    } t_utf8_req;

    // one directed row; typed rows carry their own expectation (0 or 1 request)
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       typed;
        logic [2:0] n_res;
        logic [7:0] rbyte;
        logic       rdone;
        logic [2:0] rerr;
    } t_row;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [3:0] m_axis_tuser;

    xml_char_reference_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),    // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast),    // text_done
        .m_axis_tuser  (m_axis_tuser)     // [0] last_of_run, [3:1] error_code
    );

    // bench copy of the decoder state
    t_phase      dec_phase = PH_PLAIN;
    logic [31:0] name_buf  = '0;
    logic [2:0]  name_cnt  = '0;
    logic [20:0] code_acc  = '0;
    logic        code_big  = 1'b0;
    logic        in_hex    = 1'b0;
    logic        got_digit = 1'b0;

    t_utf8_req   pred_reqs [4];
    int          pred_n;
    t_utf8_req   utf8_expect [$];
    logic [7:0]  text_q [$];

    int n_fail     = 0;
    int n_seen     = 0;
    int n_err_seen = 0;
    bit burst_mode = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d requests still expected", utf8_expect.size());
        $display("xml_char_reference_decoder test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // queue helpers
    // ------------------------------------------------------------------
    task automatic add_text_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic expect_req(input t_utf8_req r);
        utf8_expect = {utf8_expect, r};
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic clear_ref();
        name_buf  = '0;
        name_cnt  = '0;
        code_acc  = '0;
        code_big  = 1'b0;
        in_hex    = 1'b0;
        got_digit = 1'b0;
    endtask

    task automatic put_req(input logic [7:0] ch, input logic last, input logic done,
                           input logic [2:0] err);
        pred_reqs[pred_n] = '{ch, last, done, err};
        pred_n++;
    endtask

    task automatic raise_err(input logic [2:0] err, input logic eot);
        put_req(8'h00, 1'b1, 1'b1, err);
        clear_ref();
        dec_phase = eot ? PH_PLAIN : PH_DISCARD;
    endtask

    function automatic int digit_of(input logic [7:0] b, input logic hx);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (hx && b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        if (hx && b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    task automatic encode_utf8(input logic [20:0] c, input logic eot);
        logic [7:0] u [4];
        int n;
        u = '{8'h00, 8'h00, 8'h00, 8'h00};
        if (c < UTF_2B) begin
            u[0] = c[7:0];
            n = 1;
        end else if (c < UTF_3B) begin
            u[0] = 8'hC0 | {3'b0, c[10:6]};
            u[1] = 8'h80 | {2'b0, c[5:0]};
            n = 2;
        end else if (c < UTF_4B) begin
            u[0] = 8'hE0 | {4'b0, c[15:12]};
            u[1] = 8'h80 | {2'b0, c[11:6]};
            u[2] = 8'h80 | {2'b0, c[5:0]};
            n = 3;
        end else begin
            u[0] = 8'hF0 | {5'b0, c[20:18]};
            u[1] = 8'h80 | {2'b0, c[17:12]};
            u[2] = 8'h80 | {2'b0, c[11:6]};
            u[3] = 8'h80 | {2'b0, c[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
            put_req(u[k], k == n - 1, (k == n - 1) && eot, ERR_NONE);
        clear_ref();
        dec_phase = PH_PLAIN;
    endtask

    task automatic gather(input logic [7:0] b);
        int d;
        logic [31:0] v;
        if (dec_phase == PH_AMP) begin
            if (b == CH_HASH) begin
                dec_phase = PH_NUM;
                return;
            end
            dec_phase = PH_NAME;
        end
        if (dec_phase == PH_NAME) begin
            if (name_cnt < 3'd4) name_buf = {name_buf[23:0], b};
            if (name_cnt < 3'd5) name_cnt = name_cnt + 3'd1;
            return;
        end
        if (dec_phase == PH_NUM) begin
            if (!got_digit && !in_hex && (b == CH_LX || b == CH_UX)) begin
                in_hex = 1'b1;
                return;
            end
            d = digit_of(b, in_hex);
            if (d < 0) begin
                dec_phase = PH_BADNUM;
                return;
            end
            got_digit = 1'b1;
            // once past the limit the value stops moving
            if (!code_big) begin
                v = {11'd0, code_acc} * (in_hex ? 32'd16 : 32'd10) + d[31:0];
                if (v > {11'd0, CODE_LIMIT}) code_big = 1'b1;
                else code_acc = v[20:0];
            end
        end
    endtask

    task automatic close_ref(input logic eot);
        logic [7:0] c;
        bit known;
        c = 8'h00;
        if (dec_phase == PH_BADNUM) begin
            raise_err(ERR_BAD_DIGIT, eot);
        end else if (dec_phase == PH_NUM) begin
            if (!got_digit) raise_err(ERR_EMPTY, eot);
            else if (code_big) raise_err(ERR_TOO_LARGE, eot);
            else encode_utf8(code_acc, eot);
        end else if (dec_phase != PH_NAME) begin
            raise_err(ERR_UNKNOWN, eot);
        end else begin
            known = 1'b1;
            if (name_cnt == 3'd2 && name_buf == NAME_LT) c = CH_LT;
            else if (name_cnt == 3'd2 && name_buf == NAME_GT) c = CH_GT;
            else if (name_cnt == 3'd3 && name_buf == NAME_AMP) c = CH_AMP;
            else if (name_cnt == 3'd4 && name_buf == NAME_QUOT) c = CH_QUOT;
            else if (name_cnt == 3'd4 && name_buf == NAME_APOS) c = CH_APOS;
            else known = 1'b0;
            if (known) encode_utf8({13'd0, c}, eot);
            else raise_err(ERR_UNKNOWN, eot);
        end
    endtask

    task automatic decode_step(input logic [7:0] b, input logic eot);
        pred_n = 0;
        if (dec_phase == PH_DISCARD) begin
            if (eot) dec_phase = PH_PLAIN;
        end else if (dec_phase == PH_PLAIN) begin
            if (b == CH_AMP) begin
                clear_ref();
                dec_phase = PH_AMP;
                if (eot) raise_err(ERR_UNTERMINATED, eot);
            end else begin
                put_req(b, 1'b1, eot, ERR_NONE);
            end
        end else if (b == CH_SEMI) begin
            close_ref(eot);
        end else begin
            gather(b);
            if (eot) raise_err(ERR_UNTERMINATED, eot);
        end
    endtask

    // ------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 2);
        if (r < 9) return $urandom_range(3, 5);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pool_char();
        string pool = "amplgtquos";
        return pool[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] any_but_semi();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return (r == CH_SEMI) ? 8'h3A : r;
    endfunction

    function automatic string entity_name(input int k);
        case (k)
            0:       return "amp";
            1:       return "lt";
            2:       return "gt";
            3:       return "quot";
            default: return "apos";
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'h30 + d[7:0];
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + d[7:0] - 8'd10;
    endfunction

    task automatic add_number(input logic [31:0] v, input bit hx);
        logic [7:0] digs [$];
        logic [31:0] r;
        r = v;
        do begin
            digs.push_front(digit_char(hx ? int'(r % 16) : int'(r % 10)));
            r = hx ? r / 16 : r / 10;
        end while (r != 0);
        if ($urandom_range(0, 7) == 0) digs.push_front(8'h30);
        add_text_byte(CH_AMP);
        add_text_byte(CH_HASH);
        if (hx) add_text_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
        foreach (digs[k]) add_text_byte(digs[k]);
        add_text_byte(CH_SEMI);
    endtask

    task automatic add_name(input string s);
        add_text_byte(CH_AMP);
        for (int k = 0; k < s.len(); k++) add_text_byte(s[k]);
        add_text_byte(CH_SEMI);
    endtask

    function automatic logic [31:0] random_code();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'h7F);
            1:       return $urandom_range(32'h80, 32'h7FF);
            2:       return $urandom_range(32'h800, 32'hFFFF);
            default: return $urandom_range(32'h10000, 32'h1FFFFF);
        endcase
    endfunction

    task automatic build_text();
        int nseg, start, pos, cut;
        string s;
        logic [7:0] junk;
        text_q.delete();
        nseg = $urandom_range(1, 5);
        for (int g = 0; g < nseg; g++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (int k = $urandom_range(1, 4); k > 0; k--) begin
                        junk = 8'($urandom_range(0, 255));
                        add_text_byte(junk == CH_AMP ? 8'h25 : junk);
                    end
                end
                3, 4: add_name(entity_name($urandom_range(0, 4)));
                5, 6, 7: add_number(random_code(), 1'($urandom_range(0, 1)));
                8: begin
                    case ($urandom_range(0, 5))
                        0: add_name("");
                        1: begin
                            if ($urandom_range(0, 1)) add_name("#");
                            else add_name("#x");
                        end
                        2: add_number($urandom_range(32'h200000, 32'h0FFFFFFF),
                                      1'($urandom_range(0, 1)));
                        3: begin
                            s = "";
                            for (int k = $urandom_range(1, 6); k > 0; k--)
                                s = {s, string'(pool_char())};
                            add_name(s);
                        end
                        4: begin
                            // near miss of a real name
                            start = text_q.size();
                            add_name(entity_name($urandom_range(0, 4)));
                            pos = $urandom_range(start + 1, text_q.size() - 2);
                            text_q[pos] = any_but_semi();
                        end
                        default: begin
                            // a second ampersand inside the body
                            add_text_byte(CH_AMP);
                            if ($urandom_range(0, 1)) add_text_byte(pool_char());
                            add_text_byte(CH_AMP);
                            if ($urandom_range(0, 1)) add_text_byte(pool_char());
                            add_text_byte(CH_SEMI);
                        end
                    endcase
                end
                default: begin
                    // numeric reference with a stray byte among the digits
                    start = text_q.size();
                    add_number(random_code(), 1'($urandom_range(0, 1)));
                    pos = $urandom_range(start + 2, text_q.size() - 1);
                    case ($urandom_range(0, 5))
                        0:       junk = 8'h2D;
                        1:       junk = 8'h2B;
                        2:       junk = 8'h20;
                        3:       junk = CH_LX;
                        4:       junk = 8'h47;
                        default: junk = any_but_semi();
                    endcase
                    text_q.insert(pos, junk);
                end
            endcase
        end
        // sometimes end the text early, often inside a reference
        if ($urandom_range(0, 7) == 0 && text_q.size() > 1) begin
            cut = $urandom_range(0, text_q.size() - 2);
            text_q = text_q[0:cut];
        end
    endtask

    // ------------------------------------------------------------------
    // stream sides
    // ------------------------------------------------------------------
    task automatic offer_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = (burst_mode || $urandom_range(0, 1)) ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            // long hold-off so the decoder backs up into its input
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (burst_mode) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_utf8_req got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[3:1]};
            n_seen++;
            if (got.err != ERR_NONE) n_err_seen++;
            if (utf8_expect.size() == 0) begin
                $display("%0t: unexpected request byte %02h last %b done %b err %0d",
                         $time, got.ch, got.last, got.done, got.err);
                n_fail++;
            end else begin
                want = utf8_expect.pop_front();
                if (got !== want) begin
                    $display("%0t: expected byte %02h last %b done %b err %0d, got %02h %b %b %0d",
                             $time, want.ch, want.last, want.done, want.err,
                             got.ch, got.last, got.done, got.err);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_row dir_rows [N_DIR];
        t_row row;
        int n_live, n_texts, n_sent;
        n_live  = 0;
        n_texts = 0;
        n_sent  = 0;
        dir_rows = '{
            // extremes of plain bytes, then a lone ampersand ending the text
            '{8'h00,   1'b0, 1'b1, 3'd1, 8'h00, 1'b0, ERR_NONE},
            '{8'hFF,   1'b1, 1'b1, 3'd1, 8'hFF, 1'b1, ERR_NONE},
            '{CH_AMP,  1'b1, 1'b1, 3'd1, 8'h00, 1'b1, ERR_UNTERMINATED},
            // empty body, then the rest of the text is dropped
            '{CH_AMP,  1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_SEMI, 1'b0, 1'b1, 3'd1, 8'h00, 1'b1, ERR_UNKNOWN},
            '{8'h61,   1'b1, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            // numeric with no digits
            '{CH_AMP,  1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_HASH, 1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_SEMI, 1'b1, 1'b1, 3'd1, 8'h00, 1'b1, ERR_EMPTY},
            // sign in a numeric body
            '{CH_AMP,  1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_HASH, 1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h2D,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_SEMI, 1'b1, 1'b1, 3'd1, 8'h00, 1'b1, ERR_BAD_DIGIT},
            // hex code past the limit
            '{CH_AMP,  1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_HASH, 1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_LX,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h46,   1'b0, 1'b1, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_SEMI, 1'b1, 1'b1, 3'd1, 8'h00, 1'b1, ERR_TOO_LARGE},
            // code zero is sent like any other
            '{CH_AMP,  1'b0, 1'b0, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_HASH, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{8'h30,   1'b0, 1'b0, 3'd0, 8'h00, 1'b0, ERR_NONE},
            '{CH_SEMI, 1'b0, 1'b1, 3'd1, 8'h00, 1'b0, ERR_NONE}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            offer_byte(row.data, row.eot);
            decode_step(row.data, row.eot);
            if (row.typed) begin
                if (row.n_res != 0)
                    expect_req('{row.rbyte, 1'b1, row.rdone, row.rerr});
            end else begin
                for (int k = 0; k < pred_n; k++) expect_req(pred_reqs[k]);
            end
        end

        while (n_sent < RANDOM_ITEMS) begin
            if (n_texts % 20 == 2) hold_req = 1'b1;
            burst_mode = ($urandom_range(0, 3) == 0);
            build_text();
            foreach (text_q[k]) begin
                offer_byte(text_q[k], k == text_q.size() - 1);
                n_sent++;
                if (dec_phase != PH_DISCARD) n_live++;
                decode_step(text_q[k], k == text_q.size() - 1);
                for (int j = 0; j < pred_n; j++) expect_req(pred_reqs[j]);
            end
            n_texts++;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_mode = 1'b0;

        while (utf8_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d directed bytes and %0d random texts of %0d bytes (%0d not discarded)",
                 N_DIR, n_texts, n_sent, n_live);
        $display("checked %0d output requests, %0d of them error requests, %0d mismatches",
                 n_seen, n_err_seen, n_fail);
        if (n_fail == 0) begin
            $display("xml_char_reference_decoder test passed");
        end else begin
            $display("xml_char_reference_decoder test failed");
        end
        $finish;
    end

endmodule
